/* rtl/spre_pkg.sv */
// Shared widths, reset values, register indexes and controller/datapath
// command and status types for the scroll pool resist-and-ease block.
// No dependencies.
package spre_pkg;

   // Fixed-point formats
   localparam int FRAC_BITS = 16;              // fraction bits of pool, eat, pay
   localparam int POOL_BITS = 32;              // width of the owed pool
   localparam int K_BITS    = 16;              // fraction bits of pay share and scale factor

   // Port widths
   localparam int DELTA_W   = 15;
   localparam int EAT_W     = 24;
   localparam int PAY_W     = 17;
   localparam int SNAP_W    = 16;
   localparam int OUT_W     = 32;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 2;

   // Derived datapath widths
   localparam int ADD_W     = DELTA_W + FRAC_BITS;
   localparam int SUM_W     = ((ADD_W > POOL_BITS) ? ADD_W : POOL_BITS) + 1;
   localparam int NEED_W    = POOL_BITS + 1;
   localparam int REM_W     = NEED_W + 1;
   localparam int PROD_W    = POOL_BITS + PAY_W;
   localparam int DIV_CNT_W = $clog2(K_BITS);

   localparam logic [PAY_W-1:0] PAY_ONE = PAY_W'(1) << K_BITS;

   // Register reset values
   localparam logic [EAT_W-1:0]  EAT_RST   = EAT_W'(13107);
   localparam logic [PAY_W-1:0]  FRAC_RST  = PAY_W'(6554);
   localparam logic              MODE_RST  = 1'b1;
   localparam logic [SNAP_W-1:0] SNAP_RST  = SNAP_W'(2097);

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EAT_PER_TICK   = 2'd0,
      CSR_PAY_FRACTION   = 2'd1,
      CSR_SPLIT_MODE     = 2'd2,
      CSR_SNAP_THRESHOLD = 2'd3
   } spre_csr_idx_type;

   // Multiplier operand selection
   typedef enum logic [1:0] {
      MUL_REM_FRAC  = 2'd0,
      MUL_POOL_FRAC = 2'd1,
      MUL_EAT_K     = 2'd2,
      MUL_PAY_K     = 2'd3
   } spre_mul_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic             add_load;       // add delta into pool, saturate
      logic             clamp_load;     // eat = min(eat, pool), remainder
      logic             mul_en;         // register one product
      spre_mul_sel_type mul_sel;
      logic             want_load;      // wanted payout and total need
      logic             unscaled_load;  // eat and pay as wanted
      logic             div_init;       // load divider with pool
      logic             div_step;       // one quotient bit
      logic             eat_from_prod;  // scaled eat
      logic             pay_from_prod;  // payout from product
      logic             pool_settle;    // subtract and snap
      logic             out_load;       // capture result
   } spre_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic split_mode;
      logic need_over;    // eat plus pay wanted exceed the pool
      logic over_draw;    // eat plus pay exceed the pool at settle
   } spre_sts_type;

endpackage

/* rtl/spre_dpath.sv */
// Datapath of the scroll pool block: configuration registers, pool,
// shared multiplier, restoring divider and result registers.
// Depends on spre_pkg.
module spre_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [spre_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spre_pkg::CSR_W-1:0]    csr_wdata,
   input  logic [spre_pkg::DELTA_W-1:0]  req_new_delta,
   input  spre_pkg::spre_cmd_type        cmd,
   output spre_pkg::spre_sts_type        sts,
   output logic [spre_pkg::OUT_W-1:0]    rsp_pay_amount,
   output logic [spre_pkg::OUT_W-1:0]    rsp_eat_amount,
   output logic [spre_pkg::OUT_W-1:0]    rsp_pool_left
);
   import spre_pkg::*;

   function automatic logic [OUT_W-1:0] to_out(input logic [POOL_BITS-1:0] v);
      logic [POOL_BITS+OUT_W-1:0] w;
      w = (POOL_BITS+OUT_W)'(v);
      return w[OUT_W-1:0];
   endfunction

   logic [EAT_W-1:0]     eat_cfg_ff, eat_cfg_in;
   logic [PAY_W-1:0]     frac_cfg_ff, frac_cfg_in;
   logic                 mode_cfg_ff, mode_cfg_in;
   logic [SNAP_W-1:0]    snap_cfg_ff, snap_cfg_in;

   logic [POOL_BITS-1:0] pool_ff, pool_in;
   logic [POOL_BITS-1:0] eat_ff, eat_in;
   logic [POOL_BITS-1:0] pay_ff, pay_in;
   logic [POOL_BITS-1:0] want_pay_ff, want_pay_in;
   logic [NEED_W-1:0]    need_ff, need_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [K_BITS-1:0]    quo_ff, quo_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [OUT_W-1:0]     pay_out_ff, pay_out_in;
   logic [OUT_W-1:0]     eat_out_ff, eat_out_in;
   logic [OUT_W-1:0]     pool_out_ff, pool_out_in;

   logic [PAY_W-1:0]     frac_eff;
   logic [SUM_W-1:0]     sum_wide;
   logic [POOL_BITS-1:0] pool_sum;
   logic [POOL_BITS-1:0] eat_ext;
   logic [POOL_BITS-1:0] eat_min;
   logic [POOL_BITS-1:0] mul_a;
   logic [PAY_W-1:0]     mul_b;
   logic [POOL_BITS-1:0] prod_shr;
   logic [REM_W-1:0]     rem_sh;
   logic [REM_W-1:0]     need_rem;
   logic [NEED_W-1:0]    spent;
   logic [POOL_BITS-1:0] pool_rest;

   // Write configuration registers
   always_comb begin
      eat_cfg_in  = eat_cfg_ff;
      frac_cfg_in = frac_cfg_ff;
      mode_cfg_in = mode_cfg_ff;
      snap_cfg_in = snap_cfg_ff;
      if (csr_wr_en) begin
         case (spre_csr_idx_type'(csr_index))
            CSR_EAT_PER_TICK:   eat_cfg_in  = csr_wdata[EAT_W-1:0];
            CSR_PAY_FRACTION:   frac_cfg_in = csr_wdata[PAY_W-1:0];
            CSR_SPLIT_MODE:     mode_cfg_in = csr_wdata[0];
            CSR_SNAP_THRESHOLD: snap_cfg_in = csr_wdata[SNAP_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp pay share to one
   assign frac_eff = (frac_cfg_ff > PAY_ONE) ? PAY_ONE : frac_cfg_ff;

   // Add incoming delta, saturate at pool maximum
   always_comb begin
      sum_wide = SUM_W'(pool_ff) + SUM_W'({req_new_delta, {FRAC_BITS{1'b0}}});
      pool_sum = (sum_wide > SUM_W'({POOL_BITS{1'b1}})) ? {POOL_BITS{1'b1}}
                                                        : sum_wide[POOL_BITS-1:0];
   end

   // Clamp eat to the pool
   assign eat_ext = POOL_BITS'(eat_cfg_ff);
   assign eat_min = (eat_ext > pool_ff) ? pool_ff : eat_ext;

   // Select multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         MUL_REM_FRAC: begin
            mul_a = rem_ff[POOL_BITS-1:0];
            mul_b = frac_eff;
         end
         MUL_POOL_FRAC: begin
            mul_a = pool_ff;
            mul_b = frac_eff;
         end
         MUL_EAT_K: begin
            mul_a = eat_ext;
            mul_b = PAY_W'(quo_ff);
         end
         MUL_PAY_K: begin
            mul_a = want_pay_ff;
            mul_b = PAY_W'(quo_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_shr = prod_ff[K_BITS +: POOL_BITS];

   // Divider step and settle arithmetic
   assign rem_sh    = {rem_ff[REM_W-2:0], 1'b0};
   assign need_rem  = REM_W'(need_ff);
   assign spent     = NEED_W'(eat_ff) + NEED_W'(pay_ff);
   assign pool_rest = pool_ff - spent[POOL_BITS-1:0];

   // Next values of the working registers
   always_comb begin
      pool_in     = pool_ff;
      eat_in      = eat_ff;
      pay_in      = pay_ff;
      want_pay_in = want_pay_ff;
      need_in     = need_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      prod_in     = prod_ff;
      pay_out_in  = pay_out_ff;
      eat_out_in  = eat_out_ff;
      pool_out_in = pool_out_ff;

      if (cmd.add_load) pool_in = pool_sum;

      if (cmd.clamp_load) begin
         eat_in = eat_min;
         rem_in = REM_W'(pool_ff - eat_min);
      end

      if (cmd.mul_en) prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

      if (cmd.want_load) begin
         want_pay_in = prod_shr;
         need_in     = NEED_W'(eat_cfg_ff) + NEED_W'(prod_shr);
      end

      if (cmd.unscaled_load) begin
         eat_in = eat_ext;
         pay_in = want_pay_ff;
      end

      // Restoring division: k = (pool << K_BITS) / need, pool < need
      if (cmd.div_init) begin
         rem_in = REM_W'(pool_ff);
         quo_in = '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= need_rem) begin
            rem_in = rem_sh - need_rem;
            quo_in = {quo_ff[K_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[K_BITS-2:0], 1'b0};
         end
      end

      if (cmd.eat_from_prod) eat_in = prod_shr;
      if (cmd.pay_from_prod) pay_in = prod_shr;

      // Subtract what was spent, drop a remainder below the snap level
      if (cmd.pool_settle)
         pool_in = (pool_rest < POOL_BITS'(snap_cfg_ff)) ? '0 : pool_rest;

      if (cmd.out_load) begin
         pay_out_in  = to_out(pay_ff);
         eat_out_in  = to_out(eat_ff);
         pool_out_in = to_out(pool_ff);
      end
   end

   // Control state: configuration and pool
   always_ff @(posedge clock) begin
      if (reset) begin
         eat_cfg_ff  <= EAT_RST;
         frac_cfg_ff <= FRAC_RST;
         mode_cfg_ff <= MODE_RST;
         snap_cfg_ff <= SNAP_RST;
         pool_ff     <= '0;
      end else begin
         eat_cfg_ff  <= eat_cfg_in;
         frac_cfg_ff <= frac_cfg_in;
         mode_cfg_ff <= mode_cfg_in;
         snap_cfg_ff <= snap_cfg_in;
         pool_ff     <= pool_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      eat_ff      <= eat_in;
      pay_ff      <= pay_in;
      want_pay_ff <= want_pay_in;
      need_ff     <= need_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      prod_ff     <= prod_in;
      pay_out_ff  <= pay_out_in;
      eat_out_ff  <= eat_out_in;
      pool_out_ff <= pool_out_in;
   end

   assign sts.split_mode = mode_cfg_ff;
   assign sts.need_over  = need_ff > NEED_W'(pool_ff);
   assign sts.over_draw  = spent > NEED_W'(pool_ff);

   assign rsp_pay_amount = pay_out_ff;
   assign rsp_eat_amount = eat_out_ff;
   assign rsp_pool_left  = pool_out_ff;

endmodule

/* rtl/spre_ctrl.sv */
// Controller of the scroll pool block: sequences one tick through the
// datapath and owns the input and result handshakes.
// Depends on spre_pkg.
module spre_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  spre_pkg::spre_sts_type sts,
   output spre_pkg::spre_cmd_type cmd
);
   import spre_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_MULT,
      S_WANT,
      S_CHECK,
      S_DIV,
      S_SCALE_EAT,
      S_SCALE_PAY,
      S_PAY,
      S_SETTLE,
      S_OUT
   } state_type;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(K_BITS - 1);

   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.mul_sel  = MUL_REM_FRAC;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.add_load = 1'b1;
               state_in     = S_PREP;
            end
         end
         S_PREP: begin
            if (sts.split_mode) begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = MUL_POOL_FRAC;
               state_in    = S_WANT;
            end else begin
               cmd.clamp_load = 1'b1;
               state_in       = S_MULT;
            end
         end
         S_MULT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_REM_FRAC;
            state_in    = S_PAY;
         end
         S_WANT: begin
            cmd.want_load = 1'b1;
            state_in      = S_CHECK;
         end
         S_CHECK: begin
            if (sts.need_over) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end else begin
               cmd.unscaled_load = 1'b1;
               state_in          = S_SETTLE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_SCALE_EAT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SCALE_EAT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_EAT_K;
            state_in    = S_SCALE_PAY;
         end
         S_SCALE_PAY: begin
            cmd.eat_from_prod = 1'b1;
            cmd.mul_en        = 1'b1;
            cmd.mul_sel       = MUL_PAY_K;
            state_in          = S_PAY;
         end
         S_PAY: begin
            cmd.pay_from_prod = 1'b1;
            state_in          = S_SETTLE;
         end
         S_SETTLE: begin
            cmd.pool_settle = 1'b1;
            state_in        = S_OUT;
         end
         S_OUT: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/scroll_pool_resist_and_ease.sv */
// Top level of the scroll pool block: controller and datapath.
// Depends on spre_pkg, spre_ctrl, spre_dpath.
//
// Usage: each req_ transaction is one tick carrying the wheel delta that
// arrived on it. The delta joins a saturating pool of owed scroll;
// resistance eats a fixed amount and easing pays out a share of the pool,
// either eat-then-pay or as a proportional split when both cannot be met.
// Every tick gives one rsp_ transaction: payout, amount eaten, pool left.
// Registers are to be written through the csr_ port only while no tick is
// in flight; the user must keep to this, as the block does not enforce it.
// The controller works on one tick at a time and steps through PREP, MULT,
// PAY, SETTLE and OUT in eat-then-pay mode, and through PREP, WANT, CHECK,
// SETTLE and OUT in split mode when the pool covers the need, adding DIV,
// SCALE_EAT, SCALE_PAY and PAY before SETTLE when the split is scaled;
// DIV is the one-bit-per-cycle divider that forms the scale factor.
// Reset clears the pool to zero, loads register defaults and drops any
// pending result. When the receiver stalls, the result waits in the output
// register; the next tick is still accepted and computed, and its result
// waits in the datapath until the output register is taken.
module scroll_pool_resist_and_ease (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [spre_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spre_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [spre_pkg::DELTA_W-1:0]   req_new_delta,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [spre_pkg::OUT_W-1:0]     rsp_pay_amount,
   output logic [spre_pkg::OUT_W-1:0]     rsp_eat_amount,
   output logic [spre_pkg::OUT_W-1:0]     rsp_pool_left
);
   import spre_pkg::*;

   spre_cmd_type cmd;
   spre_sts_type sts;

   spre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   spre_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_new_delta  (req_new_delta),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_pay_amount (rsp_pay_amount),
      .rsp_eat_amount (rsp_eat_amount),
      .rsp_pool_left  (rsp_pool_left)
   );

`ifndef ASSERT_OFF
   // One tick at a time: busy right after a transaction is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while a tick is in flight");

   // Eat plus pay never exceed the pool they come from
   a_no_overdraw: assert property (@(posedge clock) disable iff (reset)
      cmd.pool_settle |-> !sts.over_draw)
      else $error("eat plus pay exceed the pool at settle");

   // Reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");
`endif

endmodule
